// File: hdl/tfsq_pkg.sv
// Shared types and constants for the timed frame schedule queue.
package tfsq_pkg;

   localparam int TIME_W  = 64;
   localparam int FRAME_W = 32;
   localparam int VCNT_W  = 3;
   localparam int BYTES_IN_FRAME = FRAME_W / 8;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_PLAY  = 2'd1,
      OP_DROP  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NO_FRAME = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      SQ_IDLE   = 4'b0001,
      SQ_READ   = 4'b0010,
      SQ_CHECK  = 4'b0100,
      SQ_FINISH = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_ms;
      logic [FRAME_W-1:0] frame;
   } entry_type;

endpackage

// File: hdl/tfsq_mem.sv
// Entry store with one write port and one registered read port.
module tfsq_mem import tfsq_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tfsq_cmp.sv
// Shared timestamp comparator used by every queue walk.
module tfsq_cmp import tfsq_pkg::*; (
   input  logic [TIME_W-1:0] entry_time,
   input  logic [TIME_W-1:0] ref_time,
   input  logic              strict,
   output logic              hit
);

   always_comb begin
      if (strict) begin
         hit = entry_time < ref_time;
      end else begin
         hit = entry_time <= ref_time;
      end
   end

endmodule

// File: hdl/timed_frame_schedule_queue.sv
// Timed frame schedule queue: sequencer, ring pointers and result register.
// One word at a time; the result word shows up in the same cycle as ready returns.
// An add moves each later entry up one slot and stops at an earlier or equal entry or at
// the head. A play or drop pops entries from the head, and a clear or reject goes straight
// to the result word. A result word that is not yet taken holds back the next one.
// Synchronous reset empties the queue and forgets the held frame, not the entry store.
module timed_frame_schedule_queue import tfsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64,
   parameter int CHANNELS    = 4,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [TIME_W-1:0]  req_time_ms,
   input  logic [FRAME_W-1:0] req_frame_in,
   input  logic [VCNT_W-1:0]  req_value_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_frame_fresh,
   output logic [FRAME_W-1:0] rsp_frame_out,
   output logic [CW-1:0]      rsp_queue_count
);

   localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
   localparam logic [AW:0]   DEPTH_AW = (AW + 1)'(QUEUE_DEPTH);

   seq_state_type state_ff, state_in;
   op_type        op_ff, op_in;
   status_type    status_ff, status_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [FRAME_W-1:0] held_ff, held_in;
   logic               played_ff, played_in;
   logic               fresh_ff, fresh_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      pos_ff, pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_fresh_ff, rsp_fresh_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;

   logic [FRAME_W-1:0] masked_frame;
   logic               mem_wr_en, mem_rd_en, wr_new;
   logic [AW-1:0]      rd_off, wr_off, rd_addr, wr_addr;
   entry_type          wr_data, rd_data;
   logic               cmp_hit;

   function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_AW) begin
         sum = sum - DEPTH_AW;
      end
      return sum[AW-1:0];
   endfunction

   always_comb begin
      masked_frame = '0;
      for (int i = 0; i < BYTES_IN_FRAME; i++) begin
         if ((i < CHANNELS) && (i < int'(req_value_count))) begin
            masked_frame[8*i +: 8] = req_frame_in[8*i +: 8];
         end
      end
   end

   assign rd_addr = wrap_slot(head_ff, rd_off);
   assign wr_addr = wrap_slot(head_ff, wr_off);
   assign wr_data = wr_new ? entry_type'{time_ms: time_ff, frame: frame_ff} : rd_data;

   tfsq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tfsq_cmp u_cmp (
      .entry_time (rd_data.time_ms),
      .ref_time   (time_ff),
      .strict     (op_ff == OP_DROP),
      .hit        (cmp_hit)
   );

   assign req_ready = (state_ff == SQ_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      time_in       = time_ff;
      frame_in      = frame_ff;
      held_in       = held_ff;
      played_in     = played_ff;
      fresh_in      = fresh_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fresh_in  = rsp_fresh_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      wr_new        = 1'b0;
      rd_off        = '0;
      wr_off        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_operation);
               time_in   = req_time_ms;
               frame_in  = masked_frame;
               fresh_in  = 1'b0;
               status_in = ST_OK;
               unique case (op_type'(req_operation))
                  OP_ADD: begin
                     if (req_value_count == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = SQ_FINISH;
                     end else if (count_ff >= DEPTH_C) begin
                        status_in = ST_FULL;
                        state_in  = SQ_FINISH;
                     end else begin
                        pos_in   = count_ff;
                        state_in = SQ_READ;
                     end
                  end
                  OP_PLAY, OP_DROP: begin
                     state_in = SQ_READ;
                  end
                  OP_CLEAR: begin
                     head_in   = '0;
                     count_in  = '0;
                     held_in   = '0;
                     played_in = 1'b0;
                     state_in  = SQ_FINISH;
                  end
                  default: begin
                     state_in = SQ_FINISH;
                  end
               endcase
            end
         end
         SQ_READ: begin
            if (op_ff == OP_ADD) begin
               if (pos_ff == '0) begin
                  mem_wr_en = 1'b1;
                  wr_new    = 1'b1;
                  wr_off    = '0;
                  count_in  = count_ff + CW'(1);
                  state_in  = SQ_FINISH;
               end else begin
                  mem_rd_en = 1'b1;
                  rd_off    = pos_ff[AW-1:0] - AW'(1);
                  state_in  = SQ_CHECK;
               end
            end else begin
               if (count_ff == '0) begin
                  state_in = SQ_FINISH;
               end else begin
                  mem_rd_en = 1'b1;
                  rd_off    = '0;
                  state_in  = SQ_CHECK;
               end
            end
         end
         SQ_CHECK: begin
            if (op_ff == OP_ADD) begin
               mem_wr_en = 1'b1;
               wr_off    = pos_ff[AW-1:0];
               if (cmp_hit) begin
                  wr_new   = 1'b1;
                  count_in = count_ff + CW'(1);
                  state_in = SQ_FINISH;
               end else begin
                  pos_in   = pos_ff - CW'(1);
                  state_in = SQ_READ;
               end
            end else begin
               if (cmp_hit) begin
                  if (op_ff == OP_PLAY) begin
                     held_in   = rd_data.frame;
                     played_in = 1'b1;
                     fresh_in  = 1'b1;
                  end
                  head_in  = wrap_slot(head_ff, AW'(1));
                  count_in = count_ff - CW'(1);
                  state_in = SQ_READ;
               end else begin
                  state_in = SQ_FINISH;
               end
            end
         end
         SQ_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fresh_in = fresh_ff;
               rsp_count_in = count_ff;
               if (op_ff == OP_PLAY) begin
                  rsp_status_in = played_ff ? ST_OK : ST_NO_FRAME;
                  rsp_frame_in  = played_ff ? held_ff : '0;
               end else begin
                  rsp_status_in = status_ff;
                  rsp_frame_in  = '0;
               end
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         played_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         played_ff    <= played_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      time_ff       <= time_in;
      frame_ff      <= frame_in;
      fresh_ff      <= fresh_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fresh_ff  <= rsp_fresh_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame_fresh = rsp_fresh_ff;
   assign rsp_frame_out   = rsp_frame_ff;
   assign rsp_queue_count = rsp_count_ff;

endmodule

// File: tb/sv/timed_frame_schedule_queue_test.sv
// Self-checking testbench for the timed frame schedule queue with a built-in predictor.
module timed_frame_schedule_queue_test;
   import tfsq_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   localparam int CHANNELS     = 4;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      op_type      op;
      logic [63:0] stamp;
      logic [31:0] frame;
      logic [2:0]  vcnt;
   } command_type;

   typedef struct {
      status_type  status;
      logic        fresh;
      logic [31:0] frame;
      logic [6:0]  count;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_ADD;
   logic [63:0] req_time_ms = '0;
   logic [31:0] req_frame_in = '0;
   logic [2:0]  req_value_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_frame_fresh;
   logic [31:0] rsp_frame_out;
   logic [6:0]  rsp_queue_count;

   command_type      command_backlog[$];
   frame_result_type predicted_results[$];
   entry_type        schedule_model[$];
   logic [31:0]      held_frame = '0;
   bit               has_played = 1'b0;

   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   int   queued_words = 0;
   int   accepted_words = 0;
   int   mismatches = 0;
   int   cycle_count = 0;
   bit   word_taken = 1'b0;
   logic [63:0] play_time = '0;
   command_type      next_word;
   frame_result_type seen_result;

   int   op_totals[4] = '{0, 0, 0, 0};
   int   full_rejects = 0;
   int   empty_rejects = 0;
   int   fresh_plays = 0;
   int   peak_depth = 0;

   timed_frame_schedule_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .CHANNELS   (CHANNELS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_time_ms    (req_time_ms),
      .req_frame_in   (req_frame_in),
      .req_value_count(req_value_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_frame_fresh(rsp_frame_fresh),
      .rsp_frame_out  (rsp_frame_out),
      .rsp_queue_count(rsp_queue_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timed_frame_schedule_queue_test failed");
         $finish;
      end
   end

   task automatic apply_command(input logic [1:0] op, input logic [63:0] stamp,
                                input logic [31:0] frame, input logic [2:0] vcnt);
      frame_result_type r;
      entry_type        e;
      int               pos;
      int               keep;
      r.status = ST_OK;
      r.fresh = 1'b0;
      r.frame = '0;
      op_totals[op]++;
      case (op_type'(op))
         OP_ADD: begin
            if (vcnt == 0) begin
               r.status = ST_EMPTY;
               empty_rejects++;
            end else if (schedule_model.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_rejects++;
            end else begin
               keep = (vcnt < CHANNELS) ? vcnt : CHANNELS;
               e.time_ms = stamp;
               e.frame = '0;
               for (int i = 0; i < keep && i < 4; i++) begin
                  e.frame[8*i +: 8] = frame[8*i +: 8];
               end
               pos = 0;
               while (pos < schedule_model.size() && schedule_model[pos].time_ms <= stamp) begin
                  pos++;
               end
               schedule_model.insert(pos, e);
            end
         end
         OP_PLAY: begin
            while (schedule_model.size() > 0 && schedule_model[0].time_ms <= stamp) begin
               e = schedule_model.pop_front();
               held_frame = e.frame;
               has_played = 1'b1;
               r.fresh = 1'b1;
            end
            if (has_played) begin
               r.frame = held_frame;
            end else begin
               r.status = ST_NO_FRAME;
            end
            if (r.fresh) begin
               fresh_plays++;
            end
         end
         OP_DROP: begin
            while (schedule_model.size() > 0 && schedule_model[0].time_ms < stamp) begin
               void'(schedule_model.pop_front());
            end
         end
         default: begin
            schedule_model.delete();
            held_frame = '0;
            has_played = 1'b0;
         end
      endcase
      r.count = 7'(schedule_model.size());
      if (schedule_model.size() > peak_depth) begin
         peak_depth = schedule_model.size();
      end
      predicted_results.push_back(r);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (command_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_word = command_backlog.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_word.op;
            req_time_ms <= next_word.stamp;
            req_frame_in <= next_word.frame;
            req_value_count <= next_word.vcnt;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      word_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            word_taken = 1'b1;
            accepted_words++;
            apply_command(req_operation, req_time_ms, req_frame_in, req_value_count);
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("unexpected result word: status %0d, frame_out %h, queue_count %0d",
                      rsp_status, rsp_frame_out, rsp_queue_count);
               mismatches++;
            end else begin
               seen_result = predicted_results.pop_front();
               if (rsp_status !== seen_result.status) begin
                  $error("status: expected %0d, actual %0d", seen_result.status, rsp_status);
                  mismatches++;
               end
               if (rsp_frame_fresh !== seen_result.fresh) begin
                  $error("frame_fresh: expected %0d, actual %0d",
                         seen_result.fresh, rsp_frame_fresh);
                  mismatches++;
               end
               if (rsp_frame_out !== seen_result.frame) begin
                  $error("frame_out: expected %h, actual %h", seen_result.frame, rsp_frame_out);
                  mismatches++;
               end
               if (rsp_queue_count !== seen_result.count) begin
                  $error("queue_count: expected %0d, actual %0d",
                         seen_result.count, rsp_queue_count);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic push_command(input op_type op, input logic [63:0] stamp,
                               input logic [31:0] frame, input logic [2:0] vcnt);
      command_type c;
      c.op = op;
      c.stamp = stamp;
      c.frame = frame;
      c.vcnt = vcnt;
      command_backlog.push_back(c);
      queued_words++;
   endtask

   task automatic fill_to_full();
      push_command(OP_CLEAR, {$urandom, $urandom}, $urandom, 3'($urandom_range(0, 7)));
      for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
         push_command(OP_ADD, play_time + $urandom_range(0, 20), $urandom,
                      3'($urandom_range(1, 7)));
      end
      push_command(OP_PLAY, play_time + 30, $urandom, 3'($urandom_range(0, 7)));
      play_time += 31;
   endtask

   task automatic random_command();
      int          r;
      logic [63:0] stamp;
      logic [2:0]  vcnt;
      if ($urandom_range(0, 49) == 0) begin
         case ($urandom_range(0, 2))
            0: play_time = {$urandom, $urandom};
            1: play_time = TIME_MAX - 64'd80;
            default: play_time = '0;
         endcase
      end
      r = $urandom_range(0, 99);
      stamp = play_time + $urandom_range(0, 60);
      vcnt = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      if (r < 45) begin
         push_command(OP_ADD, stamp, $urandom, vcnt);
      end else if (r < 75) begin
         push_command(OP_PLAY, stamp - 64'd30, $urandom, vcnt);
         play_time += $urandom_range(0, 25);
      end else if (r < 90) begin
         push_command(OP_DROP, stamp - 64'd30, $urandom, vcnt);
      end else if (r < 93) begin
         push_command(OP_CLEAR, stamp, $urandom, vcnt);
      end else begin
         push_command(op_type'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                      3'($urandom_range(0, 7)));
      end
   endtask

   task automatic wait_until_idle();
      while (accepted_words != queued_words || predicted_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int phase_start;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_command(OP_PLAY, 64'd0, 32'hFFFF_FFFF, 3'd4);
      push_command(OP_ADD, 64'd10, 32'hFFFF_FFFF, 3'd0);
      push_command(OP_DROP, TIME_MAX, 32'h0, 3'd0);
      push_command(OP_CLEAR, TIME_MAX, 32'hFFFF_FFFF, 3'd7);
      push_command(OP_ADD, 64'd100, 32'hFFFF_FFFF, 3'd1);
      push_command(OP_ADD, 64'd100, 32'hA5A5_A5A5, 3'd2);
      push_command(OP_ADD, 64'd50, 32'h1122_3344, 3'd3);
      push_command(OP_ADD, 64'd0, 32'h5566_7788, 3'd4);
      push_command(OP_ADD, TIME_MAX, 32'h99AA_BBCC, 3'd5);
      push_command(OP_ADD, 64'd100, 32'hDEAD_BEEF, 3'd7);
      push_command(OP_PLAY, 64'd49, 32'h0, 3'd0);
      push_command(OP_PLAY, 64'd49, 32'hFFFF_FFFF, 3'd7);
      push_command(OP_DROP, 64'd100, 32'h0, 3'd0);
      push_command(OP_PLAY, 64'd100, 32'h0, 3'd0);
      push_command(OP_PLAY, TIME_MAX - 64'd1, 32'h0, 3'd0);
      push_command(OP_PLAY, TIME_MAX, 32'h0, 3'd0);
      push_command(OP_CLEAR, 64'd0, 32'h0, 3'd0);
      push_command(OP_PLAY, TIME_MAX, 32'h0, 3'd0);
      push_command(OP_ADD, 64'd5, 32'h1234_5678, 3'd6);
      push_command(OP_DROP, 64'd5, 32'h0, 3'd0);
      push_command(OP_DROP, 64'd6, 32'h0, 3'd0);
      push_command(OP_ADD, 64'h8000_0000_0000_0000, 32'h0, 3'd4);
      push_command(OP_CLEAR, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 3'd0);
      wait_until_idle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
            default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
         endcase
         phase_start = queued_words;
         play_time = {$urandom, $urandom} >> $urandom_range(0, 63);
         if (phase % 2 == 0) begin
            fill_to_full();
         end
         while (queued_words - phase_start < 145) begin
            if ($urandom_range(0, 199) == 0) begin
               fill_to_full();
            end else begin
               random_command();
            end
         end
         wait_until_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d words: %0d adds, %0d plays, %0d drops, %0d clears.",
               accepted_words, op_totals[OP_ADD], op_totals[OP_PLAY],
               op_totals[OP_DROP], op_totals[OP_CLEAR]);
      $display("Saw %0d fresh plays, %0d full and %0d empty rejects, peak depth %0d.",
               fresh_plays, full_rejects, empty_rejects, peak_depth);
      if (mismatches == 0) begin
         $display("timed_frame_schedule_queue_test passed");
      end else begin
         $display("timed_frame_schedule_queue_test failed");
      end
      $finish;
   end

endmodule
